/* rtl/straw_view_acceptance_defines.svh */
// Assertion macros shared by the straw view acceptance RTL.
`ifndef STRAW_VIEW_ACCEPTANCE_DEFINES_SVH
`define STRAW_VIEW_ACCEPTANCE_DEFINES_SVH

// Same-cycle implication under the asynchronous active-low reset.
`define SVACC_ASSERT_NOW(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// Next-cycle implication under the asynchronous active-low reset.
`define SVACC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

/* rtl/svacc_pkg.sv */
// Types, constants and helper functions for the straw view acceptance block.
package svacc_pkg;

	localparam int NUM_REGS  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_CH    = 4;
	localparam int CH_W      = 2;
	localparam int POS_W     = 16;
	localparam int SUM_W     = POS_W + 1;
	localparam int PROD_W    = 32;
	localparam int CMP_W     = POS_W + 2;
	localparam int FRAC_W    = 15;
	localparam int VIEWS     = 4;
	localparam int CNT_W     = 3;
	localparam int ZONE_W    = 4;

	localparam logic [FRAC_W-1:0] INV_SQRT2_Q15 = 15'd23170;

	localparam logic signed [CMP_W-1:0] HALF_TRANSVERSE = 18'sd10521;
	localparam logic signed [CMP_W-1:0] HALF_VIEW_LEN   = 18'sd10500;
	localparam logic signed [POS_W-1:0] HOLE_Y_HALF     = 16'sd638;

	localparam logic [ZONE_W-1:0] ZONE_MIN_LO    = 4'd1;
	localparam logic [ZONE_W-1:0] ZONE_MIN_HI    = 4'd4;
	localparam logic [ZONE_W-1:0] ZONE_EXACT_LO  = 4'd11;
	localparam logic [ZONE_W-1:0] ZONE_EXACT_HI  = 4'd13;
	localparam logic [ZONE_W-1:0] ZONE_EXACT_OFS = 4'd10;

	localparam int VIEW_U = 0;
	localparam int VIEW_V = 1;
	localparam int VIEW_X = 2;
	localparam int VIEW_Y = 3;

	localparam logic [31:0] CFG_RESET_U [NUM_CH] = '{
		32'd4326718, 32'd10093974, 32'd1443090, 32'd4279108618
	};
	localparam logic [31:0] CFG_RESET_X [NUM_CH] = '{
		32'd24512114, 32'd33162998, 32'd18744858, 32'd4287759502
	};

	typedef struct packed {
		logic [CH_W-1:0]          chamber;
		logic signed [POS_W-1:0]  x_pos;
		logic signed [POS_W-1:0]  y_pos;
		logic [ZONE_W-1:0]        zone;
	} in_beat_t;

	typedef struct packed {
		logic             accepted;
		logic [VIEWS-1:0] view_hits;
	} out_beat_t;

	typedef struct packed {
		logic signed [POS_W-1:0] u_min;
		logic signed [POS_W-1:0] u_max;
		logic signed [POS_W-1:0] x_min;
		logic signed [POS_W-1:0] x_max;
	} bounds_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_ctl_t;

	function automatic logic signed [CMP_W-1:0] ext_pos(input logic signed [POS_W-1:0] v);
		return {{(CMP_W-POS_W){v[POS_W-1]}}, v};
	endfunction

	// floor(p / 2^15): arithmetic shift rounds toward minus infinity
	function automatic logic signed [CMP_W-1:0] scale_q15(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] sh;
		sh = p >>> FRAC_W;
		return sh[CMP_W-1:0];
	endfunction

	function automatic logic view_hit(
		input logic signed [CMP_W-1:0] across,
		input logic signed [CMP_W-1:0] along,
		input logic signed [POS_W-1:0] hmin,
		input logic signed [POS_W-1:0] hmax
	);
		logic signed [CMP_W-1:0] lo;
		logic signed [CMP_W-1:0] hi;
		logic outside;
		lo = ext_pos(hmin);
		hi = ext_pos(hmax);
		outside = ((across > hi) && (across < HALF_TRANSVERSE)) ||
			((across < lo) && (across > -HALF_TRANSVERSE));
		return outside && (along < HALF_VIEW_LEN) && (along > -HALF_VIEW_LEN);
	endfunction

endpackage

/* rtl/svacc_cfg.sv */
// Hole bound registers per chamber with write port and chamber select.
module svacc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [svacc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic [svacc_pkg::CH_W-1:0]        chamber,
	output svacc_pkg::bounds_t                bounds
);

	logic [31:0] u_bounds_q [svacc_pkg::NUM_CH];
	logic [31:0] x_bounds_q [svacc_pkg::NUM_CH];
	logic [svacc_pkg::CH_W-1:0] wr_ch;

	assign wr_ch = cfg_index[svacc_pkg::CFG_IDX_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < svacc_pkg::NUM_CH; i++) begin
				u_bounds_q[i] <= svacc_pkg::CFG_RESET_U[i];
				x_bounds_q[i] <= svacc_pkg::CFG_RESET_X[i];
			end
		end else if (cfg_we) begin
			if (cfg_index[0]) begin
				x_bounds_q[wr_ch] <= cfg_data;
			end else begin
				u_bounds_q[wr_ch] <= cfg_data;
			end
		end
	end

	logic [31:0] u_sel;
	logic [31:0] x_sel;

	always_comb begin
		u_sel = u_bounds_q[chamber];
		x_sel = x_bounds_q[chamber];
		bounds.u_max = u_sel[15:0];
		bounds.u_min = u_sel[31:16];
		bounds.x_max = x_sel[15:0];
		bounds.x_min = x_sel[31:16];
	end

endmodule

/* rtl/svacc_proj.sv */
// Projection stages: form x-y, x+y, y-x, then scale each by 1/sqrt2 in Q15.
module svacc_proj (
	input  logic                                     clk,
	input  svacc_pkg::pipe_ctl_t                     ctl,
	input  svacc_pkg::in_beat_t                      in_data,
	output svacc_pkg::in_beat_t                      beat_s2,
	output logic signed [svacc_pkg::PROD_W-1:0]      prod_diff_s2,
	output logic signed [svacc_pkg::PROD_W-1:0]      prod_sum_s2,
	output logic signed [svacc_pkg::PROD_W-1:0]      prod_rdiff_s2
);

	svacc_pkg::in_beat_t beat_s1;
	logic signed [svacc_pkg::SUM_W-1:0] diff_s1;
	logic signed [svacc_pkg::SUM_W-1:0] sum_s1;
	logic signed [svacc_pkg::SUM_W-1:0] rdiff_s1;

	logic signed [svacc_pkg::SUM_W-1:0] x_ext;
	logic signed [svacc_pkg::SUM_W-1:0] y_ext;

	assign x_ext = {in_data.x_pos[svacc_pkg::POS_W-1], in_data.x_pos};
	assign y_ext = {in_data.y_pos[svacc_pkg::POS_W-1], in_data.y_pos};

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			beat_s1  <= in_data;
			diff_s1  <= x_ext - y_ext;
			sum_s1   <= x_ext + y_ext;
			rdiff_s1 <= y_ext - x_ext;
		end
	end

	logic signed [svacc_pkg::FRAC_W:0]  coef;
	logic signed [svacc_pkg::PROD_W:0]  full_diff;
	logic signed [svacc_pkg::PROD_W:0]  full_sum;
	logic signed [svacc_pkg::PROD_W:0]  full_rdiff;

	assign coef       = {1'b0, svacc_pkg::INV_SQRT2_Q15};
	assign full_diff  = diff_s1 * coef;
	assign full_sum   = sum_s1 * coef;
	assign full_rdiff = rdiff_s1 * coef;

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			beat_s2       <= beat_s1;
			prod_diff_s2  <= full_diff[svacc_pkg::PROD_W-1:0];
			prod_sum_s2   <= full_sum[svacc_pkg::PROD_W-1:0];
			prod_rdiff_s2 <= full_rdiff[svacc_pkg::PROD_W-1:0];
		end
	end

endmodule

/* rtl/svacc_judge.sv */
// Hit stages: per-view hole and length checks, then zone decision.
module svacc_judge (
	input  logic                                 clk,
	input  svacc_pkg::pipe_ctl_t                 ctl,
	input  svacc_pkg::in_beat_t                  beat_s2,
	input  logic signed [svacc_pkg::PROD_W-1:0]  prod_diff_s2,
	input  logic signed [svacc_pkg::PROD_W-1:0]  prod_sum_s2,
	input  logic signed [svacc_pkg::PROD_W-1:0]  prod_rdiff_s2,
	input  svacc_pkg::bounds_t                   bounds,
	output svacc_pkg::out_beat_t                 out_s4
);

	logic signed [svacc_pkg::CMP_W-1:0] diff_c;
	logic signed [svacc_pkg::CMP_W-1:0] sum_c;
	logic signed [svacc_pkg::CMP_W-1:0] rdiff_c;
	logic signed [svacc_pkg::CMP_W-1:0] x_c;
	logic signed [svacc_pkg::CMP_W-1:0] y_c;
	logic [svacc_pkg::VIEWS-1:0] hits_c;

	always_comb begin
		diff_c  = svacc_pkg::scale_q15(prod_diff_s2);
		sum_c   = svacc_pkg::scale_q15(prod_sum_s2);
		rdiff_c = svacc_pkg::scale_q15(prod_rdiff_s2);
		x_c     = svacc_pkg::ext_pos(beat_s2.x_pos);
		y_c     = svacc_pkg::ext_pos(beat_s2.y_pos);
		hits_c[svacc_pkg::VIEW_U] = svacc_pkg::view_hit(diff_c, sum_c,
			bounds.u_min, bounds.u_max);
		hits_c[svacc_pkg::VIEW_V] = svacc_pkg::view_hit(sum_c, rdiff_c,
			bounds.u_min, bounds.u_max);
		hits_c[svacc_pkg::VIEW_X] = svacc_pkg::view_hit(x_c, y_c,
			bounds.x_min, bounds.x_max);
		hits_c[svacc_pkg::VIEW_Y] = svacc_pkg::view_hit(y_c, x_c,
			-svacc_pkg::HOLE_Y_HALF, svacc_pkg::HOLE_Y_HALF);
	end

	logic [svacc_pkg::VIEWS-1:0]  hits_s3;
	logic [svacc_pkg::ZONE_W-1:0] zone_s3;

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			hits_s3 <= hits_c;
			zone_s3 <= beat_s2.zone;
		end
	end

	logic [svacc_pkg::CNT_W-1:0]  count;
	logic [svacc_pkg::ZONE_W-1:0] count_ext;
	logic                         acc_c;

	always_comb begin
		count = {2'b00, hits_s3[0]} + {2'b00, hits_s3[1]} +
			{2'b00, hits_s3[2]} + {2'b00, hits_s3[3]};
		count_ext = {1'b0, count};
		acc_c = 1'b0;
		if ((zone_s3 >= svacc_pkg::ZONE_MIN_LO) && (zone_s3 <= svacc_pkg::ZONE_MIN_HI)) begin
			acc_c = (count_ext >= zone_s3);
		end else if ((zone_s3 >= svacc_pkg::ZONE_EXACT_LO) &&
			(zone_s3 <= svacc_pkg::ZONE_EXACT_HI)) begin
			acc_c = (count_ext == (zone_s3 - svacc_pkg::ZONE_EXACT_OFS));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			out_s4.accepted  <= acc_c;
			out_s4.view_hits <= hits_s3;
		end
	end

endmodule

/* rtl/straw_view_acceptance.sv */
// Top level of the straw view acceptance block: pipeline control and wiring.
//
// One input beat carries chamber, x_pos, y_pos and zone; one output beat
// carries accepted and view_hits. Both channels are valid/ready.
// The block is a four-stage pipeline: sums, Q15 multiply by 1/sqrt2,
// per-view hole checks, zone decision into the output register.
// Throughput is one beat per cycle while out_ready is high; every stage carries
// its own valid bit and loads whenever it is empty or the stage after it moves.
// When the receiver holds out_ready low, beats pile up in the stages and
// in_ready drops only once all four stages are full; nothing is lost.
// The configuration port writes one 32-bit hole bound register per cycle
// at cfg_index (even index U/V hole, odd index X hole of chamber index/2);
// write it only while no beat is in flight.
// Reset clears all valid bits and loads the default hole bounds.
module straw_view_acceptance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  svacc_pkg::in_beat_t                in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output svacc_pkg::out_beat_t               out_data,
	input  logic                               cfg_we,
	input  logic [svacc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                        cfg_data
);

	`include "straw_view_acceptance_defines.svh"

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic rdy4;
	svacc_pkg::pipe_ctl_t ctl;

	always_comb begin
		rdy4 = !v_s4 || out_ready;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		ctl.ld_s1 = rdy1;
		ctl.ld_s2 = rdy2;
		ctl.ld_s3 = rdy3;
		ctl.ld_s4 = rdy4;
	end

	assign in_ready  = rdy1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	svacc_pkg::in_beat_t beat_s2;
	logic signed [svacc_pkg::PROD_W-1:0] prod_diff_s2;
	logic signed [svacc_pkg::PROD_W-1:0] prod_sum_s2;
	logic signed [svacc_pkg::PROD_W-1:0] prod_rdiff_s2;
	svacc_pkg::bounds_t bounds;

	svacc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chamber   (beat_s2.chamber),
		.bounds    (bounds)
	);

	svacc_proj u_proj (
		.clk           (clk),
		.ctl           (ctl),
		.in_data       (in_data),
		.beat_s2       (beat_s2),
		.prod_diff_s2  (prod_diff_s2),
		.prod_sum_s2   (prod_sum_s2),
		.prod_rdiff_s2 (prod_rdiff_s2)
	);

	svacc_judge u_judge (
		.clk           (clk),
		.ctl           (ctl),
		.beat_s2       (beat_s2),
		.prod_diff_s2  (prod_diff_s2),
		.prod_sum_s2   (prod_sum_s2),
		.prod_rdiff_s2 (prod_rdiff_s2),
		.bounds        (bounds),
		.out_s4        (out_data)
	);

	`SVACC_ASSERT_NOW(a_full_when_blocked, clk, arst_n, !in_ready,
		v_s1 && v_s2 && v_s3 && v_s4 && !out_ready, "input blocked with a free stage")
	`SVACC_ASSERT_NEXT(a_s3_held, clk, arst_n, v_s3 && v_s4 && !out_ready, v_s3,
		"beat dropped from stage 3 during stall")
	`SVACC_ASSERT_NEXT(a_s1_held, clk, arst_n, v_s1 && !rdy2, v_s1,
		"beat dropped from stage 1 during stall")
	`SVACC_ASSERT_NOW(a_accept_has_hit, clk, arst_n, out_valid && out_data.accepted,
		out_data.view_hits != 4'd0, "accepted beat without any view hit")

endmodule

/* tb/straw_view_acceptance_test.sv */
// Self-checking testbench for the straw view acceptance block.
module straw_view_acceptance_test;
	timeunit 1ns;
	timeprecision 1ps;

	import svacc_pkg::*;

	localparam int TRANSVERSE_EDGE = int'(HALF_TRANSVERSE);
	localparam int VIEW_LEN_EDGE   = int'(HALF_VIEW_LEN);
	localparam int HOLE_Y_EDGE     = int'(HOLE_Y_HALF);
	localparam int ROOT_HALF_Q15   = int'(INV_SQRT2_Q15);
	localparam int LATENCY         = 4;
	localparam int PHASE_BEATS     = 120;
	localparam int PROBE_N         = 23;

	localparam logic [ZONE_W-1:0] ZONE_REJECT = 4'd0;
	localparam logic [ZONE_W-1:0] ZONE_TOP    = 4'd15;

	typedef enum int {
		HOLE_DEFAULT, HOLE_ZERO, HOLE_ALL_ONES, HOLE_WIDEST,
		HOLE_INVERTED, HOLE_TYPICAL, HOLE_RANDOM
	} hole_setting_e;

	typedef struct packed {
		in_beat_t  beat;
		logic      typed;
		out_beat_t verdict;
	} probe_row_t;

	localparam out_beat_t NO_VIEWS = '{1'b0, 4'b0000};

	localparam probe_row_t PROBE_ROWS [PROBE_N] = '{
		'{'{2'd0, 16'sh7FFF, 16'sh7FFF, ZONE_MIN_LO}, 1'b1, NO_VIEWS},
		'{'{2'd1, 16'sh8000, 16'sh8000, ZONE_MIN_HI}, 1'b1, NO_VIEWS},
		'{'{2'd2, 16'sh7FFF, 16'sh8000, ZONE_EXACT_LO}, 1'b1, NO_VIEWS},
		'{'{2'd3, 16'sh8000, 16'sh7FFF, ZONE_EXACT_HI}, 1'b1, NO_VIEWS},
		'{'{2'd0, 16'sh7FFF, 16'sh7FFF, ZONE_REJECT}, 1'b1, NO_VIEWS},
		'{'{2'd0, 16'sd0, 16'sd0, ZONE_MIN_LO}, 1'b0, NO_VIEWS},
		'{'{2'd1, 16'sd0, 16'sd0, ZONE_EXACT_LO}, 1'b0, NO_VIEWS},
		'{'{2'd2, 16'sd0, 16'sd0, ZONE_EXACT_OFS}, 1'b0, NO_VIEWS},
		'{'{2'd3, 16'sd0, 16'sd0, ZONE_TOP}, 1'b0, NO_VIEWS},
		'{'{2'd0, 16'sd10520, 16'sd0, ZONE_MIN_LO}, 1'b0, NO_VIEWS},
		'{'{2'd1, 16'sd10521, 16'sd0, ZONE_MIN_LO}, 1'b0, NO_VIEWS},
		'{'{2'd2, -16'sd10520, 16'sd100, ZONE_MIN_LO + 4'd1}, 1'b0, NO_VIEWS},
		'{'{2'd3, -16'sd10521, -16'sd100, ZONE_MIN_HI - 4'd1}, 1'b0, NO_VIEWS},
		'{'{2'd0, 16'sd0, 16'sd639, ZONE_EXACT_LO}, 1'b0, NO_VIEWS},
		'{'{2'd0, 16'sd0, 16'sd638, ZONE_EXACT_LO}, 1'b0, NO_VIEWS},
		'{'{2'd1, 16'sd0, -16'sd639, ZONE_EXACT_LO + 4'd1}, 1'b0, NO_VIEWS},
		'{'{2'd2, 16'sd0, -16'sd638, ZONE_EXACT_HI}, 1'b0, NO_VIEWS},
		'{'{2'd3, 16'sd3000, 16'sd10499, ZONE_MIN_LO}, 1'b0, NO_VIEWS},
		'{'{2'd3, 16'sd3000, 16'sd10500, ZONE_MIN_LO}, 1'b0, NO_VIEWS},
		'{'{2'd0, 16'sd5000, -16'sd2000, ZONE_MIN_LO}, 1'b0, NO_VIEWS},
		'{'{2'd1, -16'sd4000, 16'sd7000, ZONE_MIN_LO + 4'd1}, 1'b0, NO_VIEWS},
		'{'{2'd2, 16'sd7400, 16'sd7400, ZONE_MIN_LO}, 1'b0, NO_VIEWS},
		'{'{2'd1, 16'sd1, -16'sd1, ZONE_MIN_HI}, 1'b0, NO_VIEWS}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_beat_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_beat_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	logic [31:0] hole_regs [NUM_REGS];
	out_beat_t   expected_verdicts [$];
	bit          sender_steady;
	int          beats_sent;
	int          beats_checked;
	int          beats_accepted;
	int          settings_used;
	int          fail_count;

	straw_view_acceptance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic int scale_root_half(input int s);
		longint p;
		p = longint'(s) * longint'(ROOT_HALF_Q15);
		return int'(p >>> 15);
	endfunction

	function automatic bit view_struck(input int across, input int along,
			input int hole_lo, input int hole_hi);
		bit outside;
		int mag;
		outside = (across > hole_hi && across < TRANSVERSE_EDGE) ||
			(across < hole_lo && across > -TRANSVERSE_EDGE);
		mag = (along < 0) ? -along : along;
		return outside && mag < VIEW_LEN_EDGE;
	endfunction

	function automatic out_beat_t predict_acceptance(input in_beat_t b);
		int          x, y, u_lo, u_hi, x_lo, x_hi, across_u, across_v, along_v, n;
		logic [31:0] ureg, xreg;
		out_beat_t   o;
		x = $signed(b.x_pos);
		y = $signed(b.y_pos);
		ureg = hole_regs[2 * b.chamber];
		xreg = hole_regs[2 * b.chamber + 1];
		u_hi = $signed(ureg[15:0]);
		u_lo = $signed(ureg[31:16]);
		x_hi = $signed(xreg[15:0]);
		x_lo = $signed(xreg[31:16]);
		across_u = scale_root_half(x - y);
		across_v = scale_root_half(x + y);
		along_v = scale_root_half(y - x);
		o.view_hits[VIEW_U] = view_struck(across_u, across_v, u_lo, u_hi);
		o.view_hits[VIEW_V] = view_struck(across_v, along_v, u_lo, u_hi);
		o.view_hits[VIEW_X] = view_struck(x, y, x_lo, x_hi);
		o.view_hits[VIEW_Y] = view_struck(y, x, -HOLE_Y_EDGE, HOLE_Y_EDGE);
		n = $countones(o.view_hits);
		o.accepted = 1'b0;
		if (b.zone >= ZONE_MIN_LO && b.zone <= ZONE_MIN_HI)
			o.accepted = (n >= int'(b.zone));
		else if (b.zone >= ZONE_EXACT_LO && b.zone <= ZONE_EXACT_HI)
			o.accepted = (n == int'(b.zone - ZONE_EXACT_OFS));
		return o;
	endfunction

	function automatic logic [31:0] hole_value(input hole_setting_e s);
		int lo, hi, t;
		case (s)
			HOLE_ZERO:     return 32'h0000_0000;
			HOLE_ALL_ONES: return 32'hFFFF_FFFF;
			HOLE_WIDEST:   return 32'h8000_7FFF;
			HOLE_INVERTED: return 32'h7FFF_8000;
			HOLE_TYPICAL: begin
				lo = -int'($urandom_range(0, 1500));
				hi = $urandom_range(0, 1500);
				if ($urandom_range(0, 3) == 0) begin
					t = lo;
					lo = hi;
					hi = t;
				end
				return {16'(lo), 16'(hi)};
			end
			default:       return $urandom;
		endcase
	endfunction

	function automatic logic signed [POS_W-1:0] random_pos();
		int r, v;
		logic [31:0] reg_pick;
		r = $urandom_range(0, 99);
		reg_pick = hole_regs[2 * $urandom_range(0, NUM_CH - 1) + 1];
		if (r < 70) begin
			v = int'($urandom_range(0, 24000)) - 12000;
		end else if (r < 85) begin
			case ($urandom_range(0, 4))
				0: v = TRANSVERSE_EDGE;
				1: v = VIEW_LEN_EDGE;
				2: v = HOLE_Y_EDGE;
				3: v = $signed(reg_pick[15:0]);
				default: v = $signed(reg_pick[31:16]);
			endcase
			v += int'($urandom_range(0, 4)) - 2;
			if (r < 78)
				v = -v;
		end else begin
			v = int'($urandom_range(0, 65535)) - 32768;
		end
		return POS_W'(v);
	endfunction

	function automatic in_beat_t random_beat();
		in_beat_t b;
		b.chamber = CH_W'($urandom_range(0, NUM_CH - 1));
		b.x_pos = random_pos();
		b.y_pos = random_pos();
		if ($urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 1))
				b.zone = ZONE_W'($urandom_range(ZONE_MIN_LO, ZONE_MIN_HI));
			else
				b.zone = ZONE_W'($urandom_range(ZONE_EXACT_LO, ZONE_EXACT_HI));
		end else begin
			b.zone = ZONE_W'($urandom_range(0, 15));
		end
		return b;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t verdict);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		expected_verdicts.push_back(typed ? verdict : predict_acceptance(b));
		beats_sent++;
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic load_holes(input hole_setting_e s);
		logic [31:0] v;
		for (int i = 0; i < NUM_REGS; i++) begin
			v = hole_value(s);
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= v;
			hole_regs[i] = v;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(40, 150)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
			stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected beat: accepted=%0b view_hits=%b",
						out_data.accepted, out_data.view_hits);
			end else begin
				want = expected_verdicts.pop_front();
				if (out_data.accepted !== want.accepted ||
						out_data.view_hits !== want.view_hits) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"beat %0d: expected accepted=%0b view_hits=%b, ",
							"got accepted=%0b view_hits=%b"},
							beats_checked, want.accepted, want.view_hits,
							out_data.accepted, out_data.view_hits);
				end
				beats_checked++;
				if (out_data.accepted === 1'b1)
					beats_accepted++;
			end
		end
	end

	initial begin
		hole_setting_e settings [7];
		settings = '{HOLE_DEFAULT, HOLE_ZERO, HOLE_ALL_ONES, HOLE_WIDEST,
			HOLE_INVERTED, HOLE_TYPICAL, HOLE_RANDOM};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sender_steady = 1'b0;
		for (int c = 0; c < NUM_CH; c++) begin
			hole_regs[2 * c] = CFG_RESET_U[c];
			hole_regs[2 * c + 1] = CFG_RESET_X[c];
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		settings_used = 1;
		for (int i = 0; i < PROBE_N; i++)
			send_beat(PROBE_ROWS[i].beat, PROBE_ROWS[i].typed, PROBE_ROWS[i].verdict);
		foreach (settings[p]) begin
			if (settings[p] != HOLE_DEFAULT) begin
				drain_and_settle();
				load_holes(settings[p]);
			end
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n % 40 == 0)
					sender_steady = ($urandom_range(0, 3) == 0);
				send_beat(random_beat(), 1'b0, NO_VIEWS);
			end
		end
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
		$display("run covered %0d beats (%0d directed) under %0d hole settings",
			beats_sent, PROBE_N, settings_used);
		$display("%0d results checked, %0d accepted, %0d mismatches",
			beats_checked, beats_accepted, fail_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d results still pending", expected_verdicts.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* straw_view_acceptance.f */
+incdir+rtl
rtl/svacc_pkg.sv
rtl/svacc_cfg.sv
rtl/svacc_proj.sv
rtl/svacc_judge.sv
rtl/straw_view_acceptance.sv
tb/straw_view_acceptance_test.sv
